// ===== src/mfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame builder package
// Sizes, codes and the frame descriptor shared by the front end, the
// descriptor queue and the frame sequencer.
// ----------------------------------------------------------------------------
package mfb_pkg;

    // Number of words one message may hold; later words are dropped.
    localparam int MAX_WORDS   = 16;
    localparam int IDX_W       = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CNT_W       = $clog2(MAX_WORDS + 1);
    // Two banks of word storage: one fills while the other is sent.
    localparam int ADDR_W      = IDX_W + 1;
    localparam int RAM_DEPTH   = 2 ** ADDR_W;
    localparam int WORD_W      = 16;
    localparam int BYTE_W      = 8;
    localparam int LEN_W       = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [BYTE_W-1:0] SENTINEL = 8'h24;

    // One closed message waiting to be framed.
    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic [7:0]       sum;
        logic             dropped;
    } desc_t;

    // Word store write request from the front end.
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] data;
    } ram_wr_t;

endpackage

// ===== src/mailbox_frame_builder.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame builder
// Throughput: one word per cycle in while busy is low; the sequencer sends
// a frame one byte per cycle, bound by the single output byte lane.
// Reset: asynchronous, active low; empties the queue and clears all counters.
// ----------------------------------------------------------------------------
module mailbox_frame_builder
    import mfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] data_word,
    input  logic              last_word,
    output logic              byte_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              end_of_frame,
    output logic              overflowed
);

    // A word is taken on every cycle with start high and busy low. Words
    // land in one of two banks of the word store. When the word marked last
    // arrives, the front end closes the message and queues a descriptor
    // (bank, word count, checksum, drop flag) for the sequencer.
    //
    // The queue holds two descriptors, one per bank, and an entry is only
    // released after its final byte has been sent. So busy, which is simply
    // "queue full", is high exactly while both banks are claimed: one frame
    // is being sent and a second closed message is waiting behind it.
    //
    // The sequencer emits one byte per cycle with byte_valid high for that
    // single cycle; the receiver must take it.

    logic    accept;
    logic    push;
    logic    pop;
    logic    full;
    logic    head_valid;
    desc_t   push_desc;
    desc_t   head_desc;
    ram_wr_t ram_wr;

    logic [ADDR_W-1:0] rd_addr;
    logic [WORD_W-1:0] rd_data;

    assign busy   = full;
    assign accept = start && !full;

    mfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_word (data_word),
        .last_word (last_word),
        .ram_wr    (ram_wr),
        .push      (push),
        .push_desc (push_desc)
    );

    // Word store: both banks share one RAM, the bank is the top address bit.
    mfb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RAM_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mfb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_desc  (push_desc),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    mfb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_desc    (head_desc),
        .rd_data      (rd_data),
        .rd_addr      (rd_addr),
        .pop          (pop),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .overflowed   (overflowed)
    );

`ifndef SYNTH
    // Every frame opens with the sentinel after a gap in byte_valid.
    a_frame_starts_with_sentinel: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(byte_valid) |-> (out_byte == SENTINEL)
    ) else $error("frame did not start with the sentinel byte");

    // The sequencer returns to idle after the closing byte of a frame.
    a_gap_after_frame: assert property (
        @(posedge clk) disable iff (!rst_n)
        (byte_valid && end_of_frame) |=> !byte_valid
    ) else $error("byte sent directly after the end of a frame");

    // A frame is only released from the queue when one is being sent.
    a_pop_needs_entry: assert property (
        @(posedge clk) disable iff (!rst_n)
        pop |-> head_valid
    ) else $error("descriptor released from an empty queue");
`endif

endmodule

// ===== src/mfb_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mfb_front.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame builder front end
// Stores incoming words in the current bank, keeps count, checksum and the
// drop flag, and hands a descriptor to the queue when a message closes.
// ----------------------------------------------------------------------------
module mfb_front
    import mfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [WORD_W-1:0] data_word,
    input  logic              last_word,
    output ram_wr_t           ram_wr,
    output logic              push,
    output desc_t             push_desc
);

    logic             bank_reg,    bank_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [7:0]       sum_reg,     sum_next;
    logic             dropped_reg, dropped_next;

    logic             has_room;
    logic [CNT_W-1:0] count_upd;
    logic [7:0]       sum_upd;
    logic             dropped_upd;

    always_comb
    begin
        has_room    = (count_reg < CNT_W'(MAX_WORDS));
        count_upd   = count_reg;
        sum_upd     = sum_reg;
        dropped_upd = dropped_reg;
        if (has_room)
        begin
            count_upd = count_reg + CNT_W'(1);
            sum_upd   = sum_reg + data_word[7:0];
        end
        else
        begin
            dropped_upd = 1'b1;
        end

        ram_wr.en   = accept && has_room;
        ram_wr.addr = {bank_reg, count_reg[IDX_W-1:0]};
        ram_wr.data = data_word;

        push              = accept && last_word;
        push_desc.bank    = bank_reg;
        push_desc.count   = count_upd;
        push_desc.sum     = sum_upd;
        push_desc.dropped = dropped_upd;

        bank_next    = bank_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        dropped_next = dropped_reg;
        if (accept)
        begin
            if (last_word)
            begin
                // The message is closed; the next one fills the other bank.
                bank_next    = !bank_reg;
                count_next   = '0;
                sum_next     = '0;
                dropped_next = 1'b0;
            end
            else
            begin
                count_next   = count_upd;
                sum_next     = sum_upd;
                dropped_next = dropped_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_reg    <= 1'b0;
            count_reg   <= '0;
            sum_reg     <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            bank_reg    <= bank_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

// ===== src/mfb_queue.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame builder descriptor queue
// Two-entry queue of closed messages; an entry stays until its frame is sent,
// so a full queue means both banks of the word store are taken.
// ----------------------------------------------------------------------------
module mfb_queue
    import mfb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  desc_t push_desc,
    input  logic  pop,
    output logic  full,
    output logic  head_valid,
    output desc_t head_desc
);

    desc_t             entry_reg [QUEUE_DEPTH];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg,  count_next;

    always_comb
    begin
        full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        head_desc   = entry_reg[rd_ptr_reg];
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/mfb_back.sv =====
// ----------------------------------------------------------------------------
// Mailbox frame builder sequencer
// Walks one queued message: sentinel, checksum, length, then each stored
// word high byte first, one registered byte per cycle.
// ----------------------------------------------------------------------------
module mfb_back
    import mfb_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  desc_t             head_desc,
    input  logic [WORD_W-1:0] rd_data,
    output logic [ADDR_W-1:0] rd_addr,
    output logic              pop,
    output logic              byte_valid,
    output logic [BYTE_W-1:0] out_byte,
    output logic              end_of_frame,
    output logic              overflowed
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SENT  = 7'b0000010,
        S_SUM   = 7'b0000100,
        S_LENHI = 7'b0001000,
        S_LENLO = 7'b0010000,
        S_DHI   = 7'b0100000,
        S_DLO   = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  idx_reg,   idx_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg,  byte_next;
    logic              eof_reg,   eof_next;
    logic              ovf_reg,   ovf_next;
    logic [LEN_W-1:0]  len;

    always_comb
    begin
        len        = LEN_W'(head_desc.count) << 1;
        rd_addr    = {head_desc.bank, idx_reg[IDX_W-1:0]};
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = 1'b0;
        byte_next  = byte_reg;
        eof_next   = 1'b0;
        ovf_next   = head_desc.dropped;
        pop        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                idx_next = '0;
                if (head_valid)
                begin
                    state_next = S_SENT;
                end
            end
            S_SENT:
            begin
                valid_next = 1'b1;
                byte_next  = SENTINEL;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                valid_next = 1'b1;
                byte_next  = head_desc.sum;
                state_next = S_LENHI;
            end
            S_LENHI:
            begin
                valid_next = 1'b1;
                byte_next  = len[15:8];
                state_next = S_LENLO;
            end
            S_LENLO:
            begin
                // Word 0 is addressed here so it is read out by the next cycle.
                valid_next = 1'b1;
                byte_next  = len[7:0];
                eof_next   = (head_desc.count == '0);
                if (eof_next)
                begin
                    pop        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DHI;
                end
            end
            S_DHI:
            begin
                valid_next = 1'b1;
                byte_next  = rd_data[15:8];
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_DLO;
            end
            S_DLO:
            begin
                // The index already points at the next word.
                valid_next = 1'b1;
                byte_next  = rd_data[7:0];
                eof_next   = (idx_reg == head_desc.count);
                if (eof_next)
                begin
                    pop        = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_DHI;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eof_reg  <= eof_next;
        ovf_reg  <= ovf_next;
    end

    assign byte_valid   = valid_reg;
    assign out_byte     = byte_reg;
    assign end_of_frame = eof_reg;
    assign overflowed   = ovf_reg;

endmodule

// ===== sim/mailbox_frame_builder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Mailbox frame builder testbench
// Feeds message words through the start/busy port and rebuilds every frame
// in a local model of the word store and checksum. Each byte on the output
// strobe is compared field by field against the oldest predicted byte.
// ----------------------------------------------------------------------------
module mailbox_frame_builder_tb
    import mfb_pkg::*;
();

    // One predicted frame byte with its two flags.
    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              eof;
        logic              ovf;
    } frame_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [WORD_W-1:0] data_word = '0;
    logic              last_word = 1'b0;
    logic              busy;
    logic              byte_valid;
    logic [BYTE_W-1:0] out_byte;
    logic              end_of_frame;
    logic              overflowed;

    // Frame bytes predicted but not yet seen on the output, oldest first.
    frame_byte_t       pending_bytes[$];

    // Local copy of the message being collected.
    logic [WORD_W-1:0] msg_words[MAX_WORDS];
    int                msg_count = 0;
    logic [7:0]        msg_sum = '0;
    logic              msg_dropped = 1'b0;

    // Percentage of cycles in which the sender holds off before a word.
    int                idle_pct = 0;

    int                error_count = 0;
    int                words_sent = 0;
    int                frames_built = 0;
    int                overflow_frames = 0;
    int                bytes_checked = 0;

    always #4 clk = ~clk;

    mailbox_frame_builder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .data_word    (data_word),
        .last_word    (last_word),
        .byte_valid   (byte_valid),
        .out_byte     (out_byte),
        .end_of_frame (end_of_frame),
        .overflowed   (overflowed)
    );

    // Every failure goes through here: one line per mismatch, and a count.
    task automatic report_mismatch(input string msg);
        error_count++;
        $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic push_frame_byte(input logic [BYTE_W-1:0] value, input logic eof);
        frame_byte_t fb;
        fb.value = value;
        fb.eof   = eof;
        fb.ovf   = msg_dropped;
        pending_bytes.push_back(fb);
    endtask

    // Applies one accepted word to the local message. A word that finds the
    // store full only raises the drop flag; it adds nothing to the checksum
    // or to the length. The last word, stored or dropped, closes the message
    // and the whole frame is queued as expected bytes.
    task automatic build_expected_frame(input logic [WORD_W-1:0] w, input logic is_last);
        logic [LEN_W-1:0] byte_len;
        int               i;
        if (msg_count < MAX_WORDS)
        begin
            msg_words[msg_count] = w;
            msg_count++;
            // The low byte of a sum only depends on the low bytes of the terms.
            msg_sum = msg_sum + w[7:0];
        end
        else
        begin
            msg_dropped = 1'b1;
        end
        if (is_last)
        begin
            byte_len = LEN_W'(msg_count * 2);
            push_frame_byte(SENTINEL, 1'b0);
            push_frame_byte(msg_sum, 1'b0);
            push_frame_byte(byte_len[15:8], 1'b0);
            push_frame_byte(byte_len[7:0], msg_count == 0);
            for (i = 0; i < msg_count; i++)
            begin
                push_frame_byte(msg_words[i][15:8], 1'b0);
                push_frame_byte(msg_words[i][7:0], i + 1 == msg_count);
            end
            frames_built++;
            if (msg_dropped)
            begin
                overflow_frames++;
            end
            msg_count   = 0;
            msg_sum     = '0;
            msg_dropped = 1'b0;
        end
    endtask

    // Offers one word and holds it until the block takes it. Inputs only
    // change at the falling edge; busy is looked at on the rising edge, so
    // the word counts as taken at the first rising edge with busy low. On
    // return start is still high, which lets the next word follow without a
    // gap. Idle cycles put random data on the bus with start low, and the
    // block must ignore it.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic is_last);
        while ($urandom_range(99) < idle_pct)
        begin
            start     = 1'b0;
            data_word = WORD_W'($urandom);
            last_word = 1'($urandom_range(1));
            @(negedge clk);
        end
        start     = 1'b1;
        data_word = w;
        last_word = is_last;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        build_expected_frame(w, is_last);
        words_sent++;
        @(negedge clk);
    endtask

    // Random word content, weighted toward the all-zero and all-one words.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return WORD_W'($urandom);
        endcase
    endfunction

    task automatic send_message(input int n_words);
        int i;
        for (i = 0; i < n_words; i++)
        begin
            send_word(pick_word(), i == n_words - 1);
        end
    endtask

    // Lowers start and lets the block finish every queued frame. The extra
    // cycles at the end catch stray bytes that come after the last one.
    task automatic wait_for_frames();
        int waited;
        waited = 0;
        start  = 1'b0;
        while (pending_bytes.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            report_mismatch($sformatf("%0d frame bytes never arrived", pending_bytes.size()));
            pending_bytes.delete();
        end
        @(negedge clk);
    endtask

    // One-word messages at both extremes of the word: the shortest frame,
    // with the end-of-frame flag on the low data byte.
    task automatic test_single_word_frames();
        idle_pct = 0;
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b1);
        send_word(16'hA55A, 1'b1);
        wait_for_frames();
    endtask

    // Two words whose low bytes add up past 255, so the checksum wraps to 0.
    task automatic test_checksum_wrap();
        idle_pct = 0;
        send_word(16'h12FF, 1'b0);
        send_word(16'h0001, 1'b1);
        wait_for_frames();
    endtask

    // Fills the store with walking-one words, then offers a last word that
    // finds it full. That word is dropped, yet it still closes the frame,
    // which must carry the overflow flag on every byte.
    task automatic test_store_overflow();
        int i;
        idle_pct = 0;
        for (i = 0; i < MAX_WORDS; i++)
        begin
            send_word(WORD_W'(1) << (i % WORD_W), 1'b0);
        end
        send_word(16'hBEEF, 1'b1);
        wait_for_frames();
    endtask

    // Random messages until about n_target words went in. Most messages fit
    // the store; some run past it to exercise dropped words in mid-message.
    task automatic test_random_messages(input int n_target, input int pct);
        int sent;
        int n_words;
        idle_pct = pct;
        sent     = 0;
        while (sent < n_target)
        begin
            if ($urandom_range(99) < 15)
            begin
                n_words = $urandom_range(MAX_WORDS + 6, MAX_WORDS + 1);
            end
            else
            begin
                n_words = $urandom_range(MAX_WORDS, 1);
            end
            send_message(n_words);
            sent += n_words;
        end
        wait_for_frames();
    endtask

    // Output check. The block cannot be held off, so every strobed byte is
    // taken at the rising edge that ends its cycle and matched against the
    // oldest prediction.
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && byte_valid)
        begin
            bytes_checked++;
            if (pending_bytes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected byte %02h", out_byte));
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (out_byte !== want.value)
                begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, want.value));
                end
                if (end_of_frame !== want.eof)
                begin
                    report_mismatch($sformatf("end_of_frame %b, expected %b on byte %02h",
                                              end_of_frame, want.eof, want.value));
                end
                if (overflowed !== want.ovf)
                begin
                    report_mismatch($sformatf("overflowed %b, expected %b on byte %02h",
                                              overflowed, want.ovf, want.value));
                end
            end
        end
    end

    initial
    begin
        // Reset is held low and released at a falling edge.
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_single_word_frames();
        test_checksum_wrap();
        test_store_overflow();
        // Back-to-back words, then a mostly idle sender, then a light one.
        test_random_messages(70, 0);
        test_random_messages(60, 84);
        test_random_messages(55, 34);

        $display("Sent %0d words in %0d frames, %0d of them with dropped words.",
                 words_sent, frames_built, overflow_frames);
        $display("Checked %0d frame bytes under several sender idle rates.", bytes_checked);
        if (error_count == 0)
        begin
            $display("mailbox_frame_builder_tb: PASS");
        end
        else
        begin
            $display("mailbox_frame_builder_tb: FAIL");
        end
        $finish;
    end

    // Guards against a block that stops taking words or stops sending bytes.
    initial
    begin
        #2_000_000;
        $display("Timed out with %0d frame bytes still expected.", pending_bytes.size());
        $display("mailbox_frame_builder_tb: FAIL");
        $finish;
    end

endmodule

// ===== mailbox_frame_builder.f =====
src/mfb_pkg.sv
src/mfb_ram.sv
src/mfb_front.sv
src/mfb_queue.sv
src/mfb_back.sv
src/mailbox_frame_builder.sv
sim/mailbox_frame_builder_tb.sv
